[rtl/dshq_pkg.sv]
// dshq_pkg: shared types and constants for the decimating sample-hold quantizer
// used by dshq_front, dshq_fifo, dshq_back and the top level
`timescale 1ns / 1ps

package dshq_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int PHASE_W    = 25;  // phase never exceeds one in Q1.24
  localparam int STEP_W     = 32;
  localparam int FRAC_W     = 17;
  localparam int SCALE_W    = 32;
  localparam int BITS_W     = 5;
  localparam int CODE_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FIFO_DEPTH = 4;   // power of two, pointers wrap on their own
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(25'h100_0000);
  localparam logic [FRAC_W-1:0]  FRAC_ONE  = FRAC_W'(17'h1_0000);
  localparam logic [BITS_W-1:0]  MAX_CODE_BITS = BITS_W'(5'd24);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VOLTS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VOLTS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_SCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_BITS  = 3'd5;

  // one queued beat, classified by the front
  typedef struct packed {
    logic                       restart;
    logic                       sampled;
    logic signed [SAMPLE_W-1:0] voltage;
  } entry_t;

  // settings as the back uses them, already saturated and ordered
  typedef struct packed {
    logic        [FRAC_W-1:0]   frac;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic        [SCALE_W-1:0]  scale;
    logic        [CODE_W-1:0]   maxcode;
  } cfg_t;

endpackage

[rtl/decimating_sample_hold_quantizer_unit.sv]
// decimating_sample_hold_quantizer_unit: top level, settings registers and the
// front / queue / back split; depends on dshq_pkg, dshq_front, dshq_fifo, dshq_back
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// input     in         in_valid / in_stall  action, voltage
// result    out        out_valid / out_stall sampled, clipped, held_value, code
// settings  in         cfg_we               cfg_index, cfg_data
//
// a process beat runs through the back sequencer in order: settle multiply,
// held update with clamp, scale multiply, round and cap into the result register
// a restart beat loads the held value as it is popped and gives no result
// the front takes a beat every cycle until the 4-entry queue fills
// rst is synchronous; held value clears to zero, phase to one, settings to defaults
// a stalled result holds its register; the back waits in its last step until it frees

module decimating_sample_hold_quantizer_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [dshq_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dshq_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   action,
  input  logic signed [dshq_pkg::SAMPLE_W-1:0]   voltage,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   sampled,
  output logic                                   clipped,
  output logic signed [dshq_pkg::SAMPLE_W-1:0]   held_value,
  output logic [dshq_pkg::CODE_W-1:0]            code
);

  // raw settings as written
  logic [dshq_pkg::STEP_W-1:0]          phase_step;
  logic [dshq_pkg::FRAC_W-1:0]          settle_fraction;
  logic signed [dshq_pkg::SAMPLE_W-1:0] min_volts;
  logic signed [dshq_pkg::SAMPLE_W-1:0] max_volts;
  logic [dshq_pkg::SCALE_W-1:0]         code_scale;
  logic [dshq_pkg::BITS_W-1:0]          code_bits;

  // derived settings, registered: they follow the raw ones in the next cycle
  dshq_pkg::cfg_t cfg;
  dshq_pkg::cfg_t cfg_next;

  logic signed [dshq_pkg::SAMPLE_W:0]   hi_alt;
  logic [dshq_pkg::BITS_W-1:0]          bits_eff;

  logic             push;
  dshq_pkg::entry_t push_entry;
  dshq_pkg::entry_t head;
  logic             pop;
  logic             fifo_full;
  logic             fifo_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step      <= dshq_pkg::STEP_W'(32'h0100_0000);
      settle_fraction <= dshq_pkg::FRAC_ONE;
      min_volts       <= '0;
      max_volts       <= dshq_pkg::SAMPLE_W'(24'h01_0000);
      code_scale      <= dshq_pkg::SCALE_W'(32'h0000_FFFF);
      code_bits       <= dshq_pkg::BITS_W'(5'd16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        dshq_pkg::REG_PHASE_STEP: phase_step      <= cfg_data;
        dshq_pkg::REG_SETTLE:     settle_fraction <= cfg_data[dshq_pkg::FRAC_W-1:0];
        dshq_pkg::REG_MIN_VOLTS:  min_volts       <= cfg_data[dshq_pkg::SAMPLE_W-1:0];
        dshq_pkg::REG_MAX_VOLTS:  max_volts       <= cfg_data[dshq_pkg::SAMPLE_W-1:0];
        dshq_pkg::REG_CODE_SCALE: code_scale      <= cfg_data;
        dshq_pkg::REG_CODE_BITS:  code_bits       <= cfg_data[dshq_pkg::BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // unordered limits: one volt above the lower limit, saturated at full scale
  assign hi_alt = {min_volts[dshq_pkg::SAMPLE_W-1], min_volts}
                + (dshq_pkg::SAMPLE_W + 1)'(65536);

  always_comb begin
    if (code_bits == '0) begin
      bits_eff = dshq_pkg::BITS_W'(1);
    end else if (code_bits > dshq_pkg::MAX_CODE_BITS) begin
      bits_eff = dshq_pkg::MAX_CODE_BITS;
    end else begin
      bits_eff = code_bits;
    end

    cfg_next.frac  = (settle_fraction > dshq_pkg::FRAC_ONE) ? dshq_pkg::FRAC_ONE
                   : settle_fraction;
    cfg_next.lo    = min_volts;
    cfg_next.scale = code_scale;
    if (max_volts > min_volts) begin
      cfg_next.hi = max_volts;
    end else if (hi_alt > (dshq_pkg::SAMPLE_W + 1)'(24'sh7F_FFFF)) begin
      cfg_next.hi = dshq_pkg::SAMPLE_W'(24'h7F_FFFF);
    end else begin
      cfg_next.hi = hi_alt[dshq_pkg::SAMPLE_W-1:0];
    end
    cfg_next.maxcode = {dshq_pkg::CODE_W{1'b1}}
                     >> (dshq_pkg::MAX_CODE_BITS - bits_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frac    <= dshq_pkg::FRAC_ONE;
      cfg.lo      <= '0;
      cfg.hi      <= dshq_pkg::SAMPLE_W'(24'h01_0000);
      cfg.scale   <= dshq_pkg::SCALE_W'(32'h0000_FFFF);
      cfg.maxcode <= dshq_pkg::CODE_W'(24'h00_FFFF);
    end else begin
      cfg <= cfg_next;
    end
  end

  // front: phase accumulator, tags each beat as restart / sampled / held
  dshq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .voltage    (voltage),
    .phase_step (phase_step),
    .fifo_full  (fifo_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // queue lets the front keep taking beats while the back works or waits
  dshq_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (fifo_full),
    .empty      (fifo_empty)
  );

  // back: held value feedback, clamp, quantize, result register
  dshq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .empty      (fifo_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sampled    (sampled),
    .clipped    (clipped),
    .held_value (held_value),
    .code       (code)
  );

endmodule

[rtl/dshq_front.sv]
// dshq_front: input side, owns the phase accumulator and tags each beat
// depends on dshq_pkg
`timescale 1ns / 1ps

module dshq_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 action,
  input  logic signed [dshq_pkg::SAMPLE_W-1:0] voltage,
  input  logic [dshq_pkg::STEP_W-1:0]          phase_step,
  input  logic                                 fifo_full,
  output logic                                 push,
  output dshq_pkg::entry_t                     push_entry
);

  logic [dshq_pkg::PHASE_W-1:0] phase;
  logic [dshq_pkg::PHASE_W-1:0] phase_next;
  logic [dshq_pkg::STEP_W:0]    sum;
  logic                         wrap;

  assign in_stall = fifo_full;
  assign push     = in_valid && !fifo_full;

  // sum is formed without loss, wrap when it reaches one
  assign sum  = {{(dshq_pkg::STEP_W + 1 - dshq_pkg::PHASE_W){1'b0}}, phase}
              + {1'b0, phase_step};
  assign wrap = |sum[dshq_pkg::STEP_W:dshq_pkg::PHASE_W-1];

  always_comb begin
    if (action) begin
      phase_next = dshq_pkg::PHASE_ONE;
    end else if (wrap) begin
      phase_next = {1'b0, sum[dshq_pkg::PHASE_W-2:0]};
    end else begin
      phase_next = sum[dshq_pkg::PHASE_W-1:0];
    end
  end

  always_comb begin
    push_entry.restart = action;
    push_entry.sampled = !action && wrap;
    push_entry.voltage = voltage;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= dshq_pkg::PHASE_ONE;
    end else if (push) begin
      phase <= phase_next;
    end
  end

endmodule

[rtl/dshq_fifo.sv]
// dshq_fifo: short queue between front and back
// depends on dshq_pkg
`timescale 1ns / 1ps

module dshq_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dshq_pkg::entry_t push_entry,
  input  logic             pop,
  output dshq_pkg::entry_t head,
  output logic             full,
  output logic             empty
);

  dshq_pkg::entry_t               slots [dshq_pkg::FIFO_DEPTH];
  logic [dshq_pkg::FIFO_AW-1:0]   wr_ptr;
  logic [dshq_pkg::FIFO_AW-1:0]   rd_ptr;
  logic [dshq_pkg::FIFO_AW:0]     count;

  assign full  = (count == (dshq_pkg::FIFO_AW + 1)'(dshq_pkg::FIFO_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");

endmodule

[rtl/dshq_back.sv]
// dshq_back: settles the held value, clamps and quantizes, drives the result register
// depends on dshq_pkg
`timescale 1ns / 1ps

module dshq_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dshq_pkg::cfg_t                       cfg,
  input  dshq_pkg::entry_t                     head,
  input  logic                                 empty,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 sampled,
  output logic                                 clipped,
  output logic signed [dshq_pkg::SAMPLE_W-1:0] held_value,
  output logic [dshq_pkg::CODE_W-1:0]          code
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SETTLE = 4'b0010,
    ST_SCALE  = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  localparam int PROD1_W = dshq_pkg::SAMPLE_W + dshq_pkg::FRAC_W + 2;
  localparam int PROD2_W = dshq_pkg::SAMPLE_W + dshq_pkg::SCALE_W;
  localparam int CODEF_W = PROD2_W + 1 - 16;

  state_t state;
  state_t state_next;

  logic signed [dshq_pkg::SAMPLE_W-1:0] held;
  logic signed [PROD1_W-1:0]            prod1;
  logic                                 samp_r;
  logic signed [dshq_pkg::SAMPLE_W-1:0] clamp_r;
  logic                                 clip_r;
  logic [PROD2_W-1:0]                   prod2;

  logic signed [dshq_pkg::SAMPLE_W:0]   diff;
  logic signed [dshq_pkg::FRAC_W:0]     frac_s;
  logic signed [PROD1_W-1:0]            prod1_next;
  logic signed [PROD1_W-1:0]            rounded;
  logic signed [dshq_pkg::SAMPLE_W+1:0] held_sum;
  logic signed [dshq_pkg::SAMPLE_W-1:0] held_new;
  logic signed [dshq_pkg::SAMPLE_W:0]   span;
  logic [PROD2_W:0]                     prod2_rnd;
  logic [CODEF_W-1:0]                   code_full;
  logic [dshq_pkg::CODE_W-1:0]          code_next;
  logic                                 out_free;

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == ST_IDLE) && !empty;

  // settle multiply: error times fraction
  assign diff       = {head.voltage[dshq_pkg::SAMPLE_W-1], head.voltage}
                    - {held[dshq_pkg::SAMPLE_W-1], held};
  assign frac_s     = {1'b0, cfg.frac};
  assign prod1_next = PROD1_W'(diff * frac_s);

  // round half up, arithmetic shift keeps the floor for negative errors
  assign rounded  = (prod1 + PROD1_W'(32768)) >>> 16;
  assign held_sum = {{2{held[dshq_pkg::SAMPLE_W-1]}}, held}
                  + rounded[dshq_pkg::SAMPLE_W+1:0];
  assign held_new = samp_r ? held_sum[dshq_pkg::SAMPLE_W-1:0] : held;

  // clamped value minus lower limit fits the sample width unsigned
  assign span = {clamp_r[dshq_pkg::SAMPLE_W-1], clamp_r}
              - {cfg.lo[dshq_pkg::SAMPLE_W-1], cfg.lo};

  assign prod2_rnd = {1'b0, prod2} + (PROD2_W + 1)'(32768);
  assign code_full = prod2_rnd[PROD2_W:16];
  assign code_next = (code_full > CODEF_W'(cfg.maxcode)) ? cfg.maxcode
                   : code_full[dshq_pkg::CODE_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop && !head.restart) begin
          state_next = ST_SETTLE;
        end
      end
      ST_SETTLE: state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop && head.restart) begin
        held <= head.voltage;
      end else if (state == ST_SETTLE) begin
        held <= held_new;
      end
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      prod1  <= prod1_next;
      samp_r <= head.sampled;
    end
    if (state == ST_SETTLE) begin
      clip_r <= (held_new < cfg.lo) || (held_new > cfg.hi);
      if (held_new < cfg.lo) begin
        clamp_r <= cfg.lo;
      end else if (held_new > cfg.hi) begin
        clamp_r <= cfg.hi;
      end else begin
        clamp_r <= held_new;
      end
    end
    if (state == ST_SCALE) begin
      prod2 <= span[dshq_pkg::SAMPLE_W-1:0] * cfg.scale;
    end
    if (state == ST_EMIT && out_free) begin
      sampled    <= samp_r;
      clipped    <= clip_r;
      held_value <= clamp_r;
      code       <= code_next;
    end
  end

  a_restart_loads: assert property (@(posedge clk) disable iff (rst)
      pop && head.restart |=> held == $past(head.voltage))
    else $error("restart did not load held value");
  a_code_capped: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> code <= cfg.maxcode)
    else $error("code above cap");
  a_held_in_limits: assert property (@(posedge clk) disable iff (rst)
      state == ST_SCALE |-> clamp_r >= cfg.lo && clamp_r <= cfg.hi)
    else $error("clamped value outside limits");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
      state != ST_IDLE |-> !pop)
    else $error("queue popped while busy");

endmodule

[bench/decimating_sample_hold_quantizer_unit_tb.sv]
// testbench for decimating_sample_hold_quantizer_unit: directed and random beats,
// each result checked against an in-bench model of the phase, settle, clamp and code path
// depends on dshq_pkg and the unit's rtl
`timescale 1ns / 1ps

module decimating_sample_hold_quantizer_unit_tb;

  // one in Q8.24, and the signed Q8.16 range of a voltage
  localparam longint PHASE_UNIT  = 64'sd16777216;
  localparam longint VOLT_TOP    = 64'sd8388607;
  localparam longint VOLT_BOTTOM = -64'sd8388608;

  // one result beat as the unit should present it
  typedef struct packed {
    logic                                 sampled;
    logic                                 clipped;
    logic signed [dshq_pkg::SAMPLE_W-1:0] held;
    logic        [dshq_pkg::CODE_W-1:0]   code;
  } reading_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;

  // every input known from time zero
  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 cfg_we = 1'b0;
  logic [dshq_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [dshq_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic                                 action = 1'b0;
  logic signed [dshq_pkg::SAMPLE_W-1:0] voltage = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic                                 sampled;
  logic                                 clipped;
  logic signed [dshq_pkg::SAMPLE_W-1:0] held_value;
  logic [dshq_pkg::CODE_W-1:0]          code;

  // model copy of the settings, as written
  logic [dshq_pkg::STEP_W-1:0]          step_cfg;
  logic [dshq_pkg::FRAC_W-1:0]          settle_cfg;
  logic signed [dshq_pkg::SAMPLE_W-1:0] min_cfg;
  logic signed [dshq_pkg::SAMPLE_W-1:0] max_cfg;
  logic [dshq_pkg::SCALE_W-1:0]         scale_cfg;
  logic [dshq_pkg::BITS_W-1:0]          bits_cfg;

  // model copy of the held voltage and the phase accumulator
  longint                     held_model;
  longint unsigned            phase_model;

  reading_t                   expected_readings[$];
  int                         mismatches = 0;
  int                         burst_left = 0;

  stall_mode_t                stall_mode = STALL_NONE;
  int                         mode_left = 0;
  int                         run_left = 0;
  logic                       run_level = 1'b0;

  always #5 clk = ~clk;

  decimating_sample_hold_quantizer_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .voltage    (voltage),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sampled    (sampled),
    .clipped    (clipped),
    .held_value (held_value),
    .code       (code)
  );

  // advance the model by one accepted beat; returns 1 when the beat makes a result
  function automatic bit convert_sample(input logic act,
                                        input logic signed [dshq_pkg::SAMPLE_W-1:0] volt,
                                        output reading_t res);
    longint          vin, lo, hi, clamped, frac;
    longint unsigned sum, maxcode, code_val;
    int unsigned     nbits;
    res = '0;
    vin = longint'(volt);
    // restart loads the hold and rearms the phase, nothing comes out
    if (act) begin
      held_model  = vin;
      phase_model = PHASE_UNIT;
      return 1'b0;
    end
    // phase sum kept wide, so a step near the top cannot wrap
    sum = phase_model + 64'(step_cfg);
    if (sum >= PHASE_UNIT) begin
      frac = longint'(settle_cfg);
      if (frac > 65536) frac = 65536;  // settle above one saturates
      held_model  = held_model + (((vin - held_model) * frac + 64'sd32768) >>> 16);
      phase_model = sum & (PHASE_UNIT - 1);
      res.sampled = 1'b1;
    end else begin
      phase_model = sum;
    end
    // unordered limits fall back to one volt above the lower one
    lo = longint'(min_cfg);
    hi = longint'(max_cfg);
    if (hi <= lo) begin
      hi = lo + 65536;
      if (hi > VOLT_TOP) hi = VOLT_TOP;
    end
    res.clipped = (held_model < lo) || (held_model > hi);
    clamped = (held_model < lo) ? lo : ((held_model > hi) ? hi : held_model);
    // resolution forced into 1..24
    nbits = 32'(bits_cfg);
    if (nbits < 1) nbits = 1;
    if (nbits > dshq_pkg::MAX_CODE_BITS) nbits = 32'(dshq_pkg::MAX_CODE_BITS);
    maxcode  = (64'd1 << nbits) - 64'd1;
    code_val = (unsigned'(clamped - lo) * 64'(scale_cfg) + 64'd32768) >> 16;
    if (code_val > maxcode) code_val = maxcode;
    res.held = clamped[dshq_pkg::SAMPLE_W-1:0];
    res.code = code_val[dshq_pkg::CODE_W-1:0];
    return 1'b1;
  endfunction

  // one input beat, with the sender's bursts and gaps in front of it
  task automatic send_item(input logic act, input logic [dshq_pkg::SAMPLE_W-1:0] volt);
    int       gap;
    reading_t res;
    if (burst_left == 0) begin
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    action   <= act;
    voltage  <= volt;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (convert_sample(act, volt, res)) expected_readings.push_back(res);
  endtask

  // stop sending, let every result out, then give queued restarts time to drain
  task automatic wait_until_quiet();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // one register write; the enable is left high for back-to-back writes
  task automatic put_register(input logic [dshq_pkg::CFG_IDX_W-1:0] idx,
                              input logic [dshq_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // rewrite all six registers while the unit is idle, and mirror them in the model
  task automatic apply_settings(input logic [dshq_pkg::CFG_DATA_W-1:0] step_v, settle_v,
                                min_v, max_v, scale_v, bits_v);
    wait_until_quiet();
    put_register(dshq_pkg::REG_PHASE_STEP, step_v);
    put_register(dshq_pkg::REG_SETTLE, settle_v);
    put_register(dshq_pkg::REG_MIN_VOLTS, min_v);
    put_register(dshq_pkg::REG_MAX_VOLTS, max_v);
    put_register(dshq_pkg::REG_CODE_SCALE, scale_v);
    put_register(dshq_pkg::REG_CODE_BITS, bits_v);
    cfg_we    <= 1'b0;
    step_cfg   = step_v[dshq_pkg::STEP_W-1:0];
    settle_cfg = settle_v[dshq_pkg::FRAC_W-1:0];
    min_cfg    = min_v[dshq_pkg::SAMPLE_W-1:0];
    max_cfg    = max_v[dshq_pkg::SAMPLE_W-1:0];
    scale_cfg  = scale_v[dshq_pkg::SCALE_W-1:0];
    bits_cfg   = bits_v[dshq_pkg::BITS_W-1:0];
  endtask

  // reset settings: sample every beat, full settle, 0..1 V into 16 bits
  task automatic test_default_settings();
    send_item(1'b0, 24'h00_0000);
    send_item(1'b0, 24'h01_0000);
    send_item(1'b0, 24'h7F_FFFF);  // far above the upper limit
    send_item(1'b0, 24'h80_0000);  // most negative input
    send_item(1'b0, 24'h00_8000);  // half a volt, rounds at the half code
    send_item(1'b1, 24'h7F_FFFF);  // restart, no result
    send_item(1'b0, 24'h00_0001);
  endtask

  // settle saturation, largest whole-number phase step, and a zero step after a restart
  task automatic test_settle_and_phase();
    apply_settings(32'hFF00_0000, 32'h0001_FFFF, 32'h0, 32'h0001_0000, 32'd65535, 32'd16);
    send_item(1'b0, 24'h00_4000);
    send_item(1'b0, 24'h00_8000);
    send_item(1'b0, 24'h00_C000);
    // zero step: the restart arms one sample, after that the hold freezes
    apply_settings(32'h0, 32'h0000_4000, 32'h0, 32'h0001_0000, 32'd65535, 32'd16);
    send_item(1'b1, 24'h01_0000);
    send_item(1'b0, 24'h00_0000);
    send_item(1'b0, 24'h00_0000);
    send_item(1'b0, 24'h7F_FFFF);
  endtask

  // unordered and equal limits, resolution outside 1..24, widest scale
  task automatic test_limits_and_resolution();
    // lower limit near the top, upper one below it: the fallback saturates
    apply_settings(32'h0100_0000, 32'h0001_0000, 32'h007F_FF00, 32'h0, 32'hFFFF_FFFF, 32'd0);
    send_item(1'b0, 24'h7F_FFFF);
    send_item(1'b0, 24'h7F_FEFF);
    send_item(1'b0, 24'h7F_FF80);
    // full range, resolution above the cap
    apply_settings(32'h0100_0000, 32'h0001_0000, 32'hFF80_0000, 32'h007F_FFFF, 32'hFFFF_FFFF,
                   32'd31);
    send_item(1'b0, 24'h80_0000);
    send_item(1'b0, 24'h7F_FFFF);
    send_item(1'b0, 24'h00_0000);
    // equal limits, no settling, half-rate phase
    apply_settings(32'h0080_0000, 32'h0, 32'h0, 32'h0, 32'h0000_0100, 32'd24);
    send_item(1'b1, 24'h01_2345);
    send_item(1'b0, 24'hFF_FFFF);
    send_item(1'b0, 24'h00_8000);
  endtask

  // phases of random settings, each followed by a random stream
  task automatic test_random_streams();
    longint      lo_v, hi_v, hi_eff, span, scale_l, v, off;
    logic [31:0] step_v, settle_v, scale_v, bits_v;
    int          nb, roll;
    logic        act;
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 5))
        0:       step_v = 32'h0100_0000;
        1:       step_v = $urandom_range(0, 32'h00FF_FFFF);
        2:       step_v = $urandom_range(32'h0010_0000, 32'h0100_0000);
        3:       step_v = $urandom_range(32'h0100_0000, 32'hFF00_0000);
        4:       step_v = 32'h0080_0000;
        default: step_v = ph[0] ? 32'h0 : 32'hFF00_0000;
      endcase
      case ($urandom_range(0, 3))
        0:       settle_v = 32'd65536;
        1:       settle_v = 32'd0;
        default: settle_v = $urandom_range(0, 65536);
      endcase
      lo_v = longint'($urandom_range(0, 32'h00FF_FFFF)) + VOLT_BOTTOM;
      if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 2))
          0:       hi_v = lo_v + longint'($urandom_range(1, 256));
          1:       hi_v = lo_v + longint'($urandom_range(1, 32'h0004_0000));
          default: hi_v = lo_v + longint'($urandom_range(1, 32'h0100_0000));
        endcase
        if (hi_v > VOLT_TOP) hi_v = VOLT_TOP;
      end else begin
        // unordered limits
        hi_v = lo_v - longint'($urandom_range(0, 1000));
        if (hi_v < VOLT_BOTTOM) hi_v = VOLT_BOTTOM;
      end
      hi_eff = hi_v;
      if (hi_v <= lo_v) hi_eff = (lo_v + 65536 > VOLT_TOP) ? VOLT_TOP : lo_v + 65536;
      span = hi_eff - lo_v;
      if (span < 1) span = 1;
      bits_v = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 24) : $urandom_range(0, 31);
      nb = int'(bits_v);
      if (nb < 1) nb = 1;
      if (nb > 24) nb = 24;
      // mostly a scale that matches the span, sometimes anything
      roll = $urandom_range(0, 9);
      if (roll < 6) begin
        scale_l = (((longint'(1) << nb) - 1) << 16) / span;
        if (scale_l > 64'sh0_FFFF_FFFF) scale_l = 64'sh0_FFFF_FFFF;
        scale_v = scale_l[31:0];
      end else if (roll < 9) begin
        scale_v = $urandom();
      end else begin
        scale_v = 32'hFFFF_FFFF;
      end
      apply_settings(step_v, settle_v, lo_v[31:0], hi_v[31:0], scale_v, bits_v);

      repeat (165) begin
        act  = ($urandom_range(0, 99) < 8);
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
          v = longint'($urandom_range(0, 32'h00FF_FFFF)) + VOLT_BOTTOM;
        end else if (roll < 75) begin
          // around the window, a quarter of the span past either limit
          off = longint'($urandom_range(0, 32'(span + span / 2))) - span / 4;
          v = lo_v + off;
        end else if (roll < 90) begin
          // a few lsbs either side of a limit
          v = ($urandom_range(0, 1) ? hi_eff : lo_v) + longint'($urandom_range(0, 6)) - 3;
        end else begin
          case ($urandom_range(0, 2))
            0:       v = VOLT_TOP;
            1:       v = VOLT_BOTTOM;
            default: v = 0;
          endcase
        end
        if (v > VOLT_TOP) v = VOLT_TOP;
        if (v < VOLT_BOTTOM) v = VOLT_BOTTOM;
        send_item(act, v[dshq_pkg::SAMPLE_W-1:0]);
      end
    end
  endtask

  // receiver stall: modes of random length, one of them never stalls
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(50, 300);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default: begin
          if (run_left == 0) begin
            run_left  = $urandom_range(1, 16);
            run_level = ~run_level;
          end
          run_left--;
          out_stall <= run_level;
        end
      endcase
    end
  end

  // every accepted result beat against the oldest expectation
  always @(posedge clk) begin : check_results
    reading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: sampled %0b clipped %0b held %0d code %0d",
                   sampled, clipped, held_value, code);
      end else begin
        want = expected_readings.pop_front();
        if (sampled !== want.sampled || clipped !== want.clipped ||
            held_value !== want.held || code !== want.code) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: want s%0b c%0b held %0d code %0d, ",
                      "got s%0b c%0b held %0d code %0d"},
                     want.sampled, want.clipped, want.held, want.code,
                     sampled, clipped, held_value, code);
        end
      end
    end
  end

  initial begin
    // model state as the unit leaves reset
    step_cfg    = 32'h0100_0000;
    settle_cfg  = 17'h1_0000;
    min_cfg     = '0;
    max_cfg     = 24'h01_0000;
    scale_cfg   = 32'd65535;
    bits_cfg    = 5'd16;
    held_model  = 0;
    phase_model = PHASE_UNIT;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_default_settings();
    test_settle_and_phase();
    test_limits_and_resolution();
    test_random_streams();
    wait_until_quiet();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
